// ----- sv/rsdd_pkg.sv -----
`default_nettype none
package rsdd_pkg;

  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int RANGE_BITS_DEF  = 16;

  localparam int IDX_W      = 12;
  localparam int OUT_RNG_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int THR_W      = 16;
  localparam int COFF_W     = 16;
  localparam int IOFF_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFFSET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_OFFSET   = 2'd2;

  localparam logic [THR_W-1:0]  JUMP_THRESHOLD_RST = 16'd800;
  localparam logic [COFF_W-1:0] CENTER_OFFSET_RST  = 16'd445;
  localparam logic [IOFF_W-1:0] INDEX_OFFSET_RST   = 8'd20;

  typedef struct packed {
    logic [THR_W-1:0]  jump_threshold_mm;
    logic [COFF_W-1:0] center_offset_mm;
    logic [IOFF_W-1:0] index_offset;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]     seg_start;
    logic [IDX_W-1:0]     seg_end;
    logic [IDX_W-1:0]     closest_index;
    logic [OUT_RNG_W-1:0] center_range_mm;
    logic                 scan_done;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/rsdd_in_stage.sv -----
`default_nettype none
module rsdd_in_stage #(
  parameter int RANGE_BITS = rsdd_pkg::RANGE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [RANGE_BITS-1:0] in_range_mm,
  input  wire logic                  in_last_sample,
  input  wire logic                  advance,
  output logic                       item_valid,
  output logic [RANGE_BITS-1:0]      item_range,
  output logic                       item_last
);

  logic                  valid_r;
  logic [RANGE_BITS-1:0] range_r;
  logic                  last_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item_range = range_r;
  assign item_last  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      range_r <= in_range_mm;
      last_r  <= in_last_sample;
    end
  end

endmodule
`default_nettype wire

// ----- sv/rsdd_judge.sv -----
`default_nettype none
module rsdd_judge #(
  parameter int MAX_SAMPLES = rsdd_pkg::MAX_SAMPLES_DEF,
  parameter int RANGE_BITS  = rsdd_pkg::RANGE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  advance,
  input  wire logic [RANGE_BITS-1:0] cur,
  input  wire logic                  last,
  input  wire rsdd_pkg::cfg_t        cfg,
  output logic                       emit,
  output rsdd_pkg::result_t          result
);

  localparam int CNT_W = $clog2(MAX_SAMPLES);
  localparam int IW    = (CNT_W > rsdd_pkg::IDX_W) ? CNT_W : rsdd_pkg::IDX_W;
  localparam int RW    = (RANGE_BITS > rsdd_pkg::OUT_RNG_W) ? RANGE_BITS : rsdd_pkg::OUT_RNG_W;
  localparam int SW    = RW + 1;
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_SAMPLES - 1);
  localparam logic [IW:0]       IDX_SAT   = (IW + 1)'((1 << rsdd_pkg::IDX_W) - 1);
  localparam logic [SW-1:0]     RNG_SAT   = SW'({RANGE_BITS{1'b1}});

  logic [RANGE_BITS-1:0] older_r, older_nxt;
  logic [RANGE_BITS-1:0] newer_r, newer_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  open_r, open_nxt;
  logic                  seen_r, seen_nxt;
  logic [CNT_W-1:0]      ostart_r, ostart_nxt;
  logic [RANGE_BITS-1:0] minr_r, minr_nxt;
  logic [CNT_W-1:0]      mini_r, mini_nxt;

  logic [CNT_W-1:0] j;
  logic [SW-1:0]    mid_sum;
  logic             is_start;
  logic             is_end;
  logic [CNT_W-1:0] e_start;
  logic [CNT_W-1:0] e_end;
  logic             e_done;
  logic [RANGE_BITS-1:0] e_minr;
  logic [CNT_W-1:0] e_mini;
  logic [IW:0]      ci_sum;
  logic [SW-1:0]    cr_sum;
  logic [IW-1:0]    s_ext;
  logic [IW-1:0]    e_ext;

  assign j        = cnt_r - CNT_W'(1);
  assign mid_sum  = SW'(newer_r) + SW'(cfg.jump_threshold_mm);
  assign is_start = mid_sum < SW'(older_r);
  assign is_end   = mid_sum < SW'(cur);

  always_comb begin
    older_nxt  = older_r;
    newer_nxt  = newer_r;
    cnt_nxt    = cnt_r;
    open_nxt   = open_r;
    seen_nxt   = seen_r;
    ostart_nxt = ostart_r;
    minr_nxt   = minr_r;
    mini_nxt   = mini_r;
    emit       = 1'b0;
    e_start    = '0;
    e_end      = '0;
    e_done     = 1'b0;
    e_minr     = minr_r;
    e_mini     = mini_r;

    if (cnt_r == '0 && !seen_r && cur < minr_nxt) begin
      minr_nxt = cur;
      mini_nxt = '0;
    end

    if (cnt_r >= CNT_W'(2)) begin
      if (is_start) begin
        open_nxt   = 1'b1;
        seen_nxt   = 1'b1;
        ostart_nxt = j;
        minr_nxt   = newer_r;
        mini_nxt   = j;
      end else begin
        if ((open_nxt || !seen_nxt) && newer_r < minr_nxt) begin
          minr_nxt = newer_r;
          mini_nxt = j;
        end
        if (is_end && (open_nxt || !seen_nxt)) begin
          emit     = 1'b1;
          e_start  = open_nxt ? ostart_nxt : '0;
          e_end    = j;
          e_done   = last;
          e_minr   = minr_nxt;
          e_mini   = mini_nxt;
          open_nxt = 1'b0;
          seen_nxt = 1'b1;
          minr_nxt = '1;
          mini_nxt = '0;
        end
      end
    end

    if (last) begin
      if (open_nxt) begin
        emit    = 1'b1;
        e_start = ostart_nxt;
        e_end   = cnt_r;
        e_done  = 1'b1;
        if (cur < minr_nxt) begin
          e_minr = cur;
          e_mini = cnt_r;
        end else begin
          e_minr = minr_nxt;
          e_mini = mini_nxt;
        end
      end
      older_nxt  = '0;
      newer_nxt  = '0;
      cnt_nxt    = '0;
      open_nxt   = 1'b0;
      seen_nxt   = 1'b0;
      ostart_nxt = '0;
      minr_nxt   = '1;
      mini_nxt   = '0;
    end else begin
      older_nxt = newer_r;
      newer_nxt = cur;
      if (cnt_r < CNT_MAX) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  assign ci_sum = (IW + 1)'(e_mini) + (IW + 1)'(cfg.index_offset);
  assign cr_sum = SW'(e_minr) + SW'(cfg.center_offset_mm);
  assign s_ext  = IW'(e_start);
  assign e_ext  = IW'(e_end);

  always_comb begin
    result.seg_start     = s_ext[rsdd_pkg::IDX_W-1:0];
    result.seg_end       = e_ext[rsdd_pkg::IDX_W-1:0];
    result.closest_index = (ci_sum > IDX_SAT) ? IDX_SAT[rsdd_pkg::IDX_W-1:0]
                                              : ci_sum[rsdd_pkg::IDX_W-1:0];
    result.center_range_mm = (cr_sum > RNG_SAT) ? RNG_SAT[rsdd_pkg::OUT_RNG_W-1:0]
                                                : cr_sum[rsdd_pkg::OUT_RNG_W-1:0];
    result.scan_done     = e_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r  <= '0;
      newer_r  <= '0;
      cnt_r    <= '0;
      open_r   <= 1'b0;
      seen_r   <= 1'b0;
      ostart_r <= '0;
      minr_r   <= '1;
      mini_r   <= '0;
    end else if (advance) begin
      older_r  <= older_nxt;
      newer_r  <= newer_nxt;
      cnt_r    <= cnt_nxt;
      open_r   <= open_nxt;
      seen_r   <= seen_nxt;
      ostart_r <= ostart_nxt;
      minr_r   <= minr_nxt;
      mini_r   <= mini_nxt;
    end
  end

  a_open_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> seen_r) else $error("open depression without a start");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX) else $error("sample count past its limit");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && last |=> cnt_r == '0 && !open_r && !seen_r)
    else $error("scan state not cleared after the last sample");

  a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
    advance && emit |=> !open_r) else $error("depression still open after a result");

endmodule
`default_nettype wire

// ----- sv/rsdd_out_stage.sv -----
`default_nettype none
module rsdd_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire rsdd_pkg::result_t result,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output rsdd_pkg::result_t      out_data
);

  logic              valid_r;
  rsdd_pkg::result_t data_r;

  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule
`default_nettype wire

// ----- sv/range_scan_depression_detector.sv -----
`default_nettype none
// Finds depressions in a stream of range samples, one sample per transaction, and
// reports each closed depression with its start, end, closest index and center
// range. A new sample can be taken every clock cycle. It is held in an input register,
// judged by combinational compare and minimum logic, and any result is held in an
// output register. Throughput is one sample per cycle. A result is loaded into the
// output register as the sample that closes it is judged, and is held there until
// taken. The input is held off only while the output register holds a result
// that has not been taken and the input register holds a sample still to be judged.
// Configuration writes take effect at once and are meant to happen while the block
// is idle.
module range_scan_depression_detector #(
  parameter int MAX_SAMPLES = rsdd_pkg::MAX_SAMPLES_DEF,
  parameter int RANGE_BITS  = rsdd_pkg::RANGE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [RANGE_BITS-1:0]             in_range_mm,
  input  wire logic                              in_last_sample,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [rsdd_pkg::IDX_W-1:0]             out_seg_start,
  output logic [rsdd_pkg::IDX_W-1:0]             out_seg_end,
  output logic [rsdd_pkg::IDX_W-1:0]             out_closest_index,
  output logic [rsdd_pkg::OUT_RNG_W-1:0]         out_center_range_mm,
  output logic                                   out_scan_done,
  input  wire logic                              cfg_we,
  input  wire logic [rsdd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rsdd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  rsdd_pkg::cfg_t    cfg_r;
  rsdd_pkg::result_t result;
  rsdd_pkg::result_t out_data;
  logic                  item_valid;
  logic [RANGE_BITS-1:0] item_range;
  logic                  item_last;
  logic                  advance;
  logic                  emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.jump_threshold_mm <= rsdd_pkg::JUMP_THRESHOLD_RST;
      cfg_r.center_offset_mm  <= rsdd_pkg::CENTER_OFFSET_RST;
      cfg_r.index_offset      <= rsdd_pkg::INDEX_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rsdd_pkg::REG_JUMP_THRESHOLD: begin
          cfg_r.jump_threshold_mm <= cfg_wdata[rsdd_pkg::THR_W-1:0];
        end
        rsdd_pkg::REG_CENTER_OFFSET: begin
          cfg_r.center_offset_mm <= cfg_wdata[rsdd_pkg::COFF_W-1:0];
        end
        rsdd_pkg::REG_INDEX_OFFSET: begin
          cfg_r.index_offset <= cfg_wdata[rsdd_pkg::IOFF_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign advance = item_valid && (!out_valid || out_ready);

  rsdd_in_stage #(
    .RANGE_BITS(RANGE_BITS)
  ) u_in_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_range_mm   (in_range_mm),
    .in_last_sample(in_last_sample),
    .advance       (advance),
    .item_valid    (item_valid),
    .item_range    (item_range),
    .item_last     (item_last)
  );

  rsdd_judge #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .RANGE_BITS (RANGE_BITS)
  ) u_judge (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(advance),
    .cur    (item_range),
    .last   (item_last),
    .cfg    (cfg_r),
    .emit   (emit),
    .result (result)
  );

  rsdd_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance && emit),
    .result   (result),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  assign out_seg_start       = out_data.seg_start;
  assign out_seg_end         = out_data.seg_end;
  assign out_closest_index   = out_data.closest_index;
  assign out_center_range_mm = out_data.center_range_mm;
  assign out_scan_done       = out_data.scan_done;

endmodule
`default_nettype wire

// ----- tb/range_scan_depression_detector_tb.sv -----
`default_nettype none
module range_scan_depression_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [15:0] range_list_t[$];

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_range_mm = '0;
  logic in_last_sample = 1'b0;

  logic out_valid;
  logic out_ready = 1'b0;
  logic [rsdd_pkg::IDX_W-1:0] out_seg_start;
  logic [rsdd_pkg::IDX_W-1:0] out_seg_end;
  logic [rsdd_pkg::IDX_W-1:0] out_closest_index;
  logic [rsdd_pkg::OUT_RNG_W-1:0] out_center_range_mm;
  logic out_scan_done;

  logic cfg_we = 1'b0;
  logic [rsdd_pkg::CFG_IDX_W-1:0] cfg_index = rsdd_pkg::REG_JUMP_THRESHOLD;
  logic [rsdd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state: configuration copy and per-scan tracking.
  logic [rsdd_pkg::THR_W-1:0] model_threshold = rsdd_pkg::JUMP_THRESHOLD_RST;
  logic [rsdd_pkg::COFF_W-1:0] model_center_offset = rsdd_pkg::CENTER_OFFSET_RST;
  logic [rsdd_pkg::IOFF_W-1:0] model_index_offset = rsdd_pkg::INDEX_OFFSET_RST;
  logic [15:0] range_older = '0;
  logic [15:0] range_newer = '0;
  logic [rsdd_pkg::IDX_W-1:0] samples_seen = '0;
  bit dip_open = 1'b0;
  bit dip_start_seen = 1'b0;
  logic [rsdd_pkg::IDX_W-1:0] dip_start = '0;
  logic [15:0] dip_min_range = '1;
  logic [rsdd_pkg::IDX_W-1:0] dip_min_index = '0;

  rsdd_pkg::result_t pending_segments[$];
  int errors = 0;
  int unsigned sent_items = 0;
  bit sender_gaps = 1'b0;
  bit receiver_gaps = 1'b0;
  bit hold_request = 1'b0;

  range_scan_depression_detector dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_range_mm(in_range_mm),
    .in_last_sample(in_last_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_seg_start(out_seg_start),
    .out_seg_end(out_seg_end),
    .out_closest_index(out_closest_index),
    .out_center_range_mm(out_center_range_mm),
    .out_scan_done(out_scan_done),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void clear_scan_state();
    range_older = '0;
    range_newer = '0;
    samples_seen = '0;
    dip_open = 1'b0;
    dip_start_seen = 1'b0;
    dip_start = '0;
    dip_min_range = '1;
    dip_min_index = '0;
  endfunction

  function automatic void note_minimum(logic [15:0] r, logic [rsdd_pkg::IDX_W-1:0] idx);
    if (r < dip_min_range) begin
      dip_min_range = r;
      dip_min_index = idx;
    end
  endfunction

  function automatic void close_segment(logic [rsdd_pkg::IDX_W-1:0] first,
                                        logic [rsdd_pkg::IDX_W-1:0] last_idx, bit done);
    rsdd_pkg::result_t seg;
    logic [rsdd_pkg::IDX_W:0] idx_sum;
    logic [16:0] rng_sum;
    idx_sum = {1'b0, dip_min_index} + model_index_offset;
    rng_sum = {1'b0, dip_min_range} + model_center_offset;
    seg.seg_start = first;
    seg.seg_end = last_idx;
    seg.closest_index = idx_sum[rsdd_pkg::IDX_W] ? '1 : idx_sum[rsdd_pkg::IDX_W-1:0];
    seg.center_range_mm = rng_sum[16] ? '1 : rng_sum[15:0];
    seg.scan_done = done;
    pending_segments = {pending_segments, seg};
    dip_open = 1'b0;
    dip_start_seen = 1'b1;
    dip_min_range = '1;
    dip_min_index = '0;
  endfunction

  // A sample is judged one transaction late, once its right-hand neighbor is known.
  function automatic void judge_sample(logic [15:0] r, bit last);
    logic [rsdd_pkg::IDX_W-1:0] k;
    logic [rsdd_pkg::IDX_W-1:0] j;
    logic [16:0] mid_plus;
    k = samples_seen;
    if (k == 0 && !dip_start_seen) note_minimum(r, '0);
    if (k >= 2) begin
      j = k - 1'b1;
      mid_plus = {1'b0, range_newer} + model_threshold;
      if (mid_plus < {1'b0, range_older}) begin
        dip_open = 1'b1;
        dip_start_seen = 1'b1;
        dip_start = j;
        dip_min_range = range_newer;
        dip_min_index = j;
      end else begin
        if (dip_open || !dip_start_seen) note_minimum(range_newer, j);
        if (mid_plus < {1'b0, r}) begin
          if (dip_open) close_segment(dip_start, j, last);
          else if (!dip_start_seen) close_segment('0, j, last);
        end
      end
    end
    if (last) begin
      if (dip_open) begin
        note_minimum(r, k);
        close_segment(dip_start, k, 1'b1);
      end
      clear_scan_state();
    end else begin
      range_older = range_newer;
      range_newer = r;
      if (samples_seen != '1) samples_seen = samples_seen + 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_sample(input logic [15:0] r, input bit last);
    if (sender_gaps && $urandom_range(5, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_range_mm <= r;
    in_last_sample <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    judge_sample(r, last);
    sent_items++;
  endtask

  task automatic send_scan(input range_list_t samples);
    foreach (samples[i]) send_sample(samples[i], i == samples.size() - 1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rsdd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rsdd_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rsdd_pkg::REG_JUMP_THRESHOLD: model_threshold = value;
      rsdd_pkg::REG_CENTER_OFFSET: model_center_offset = value;
      rsdd_pkg::REG_INDEX_OFFSET: model_index_offset = value[rsdd_pkg::IOFF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [rsdd_pkg::THR_W-1:0] thr,
                            input logic [rsdd_pkg::COFF_W-1:0] coff,
                            input logic [rsdd_pkg::IOFF_W-1:0] ioff);
    write_reg(rsdd_pkg::REG_JUMP_THRESHOLD, thr);
    write_reg(rsdd_pkg::REG_CENTER_OFFSET, coff);
    write_reg(rsdd_pkg::REG_INDEX_OFFSET,
              {{(rsdd_pkg::CFG_DATA_W-rsdd_pkg::IOFF_W){1'b0}}, ioff});
  endtask

  // Scans alternate between a high level and dips that clear the current threshold,
  // with some samples drawn over the full range.
  task automatic send_random_scan();
    int len;
    int thr;
    int hi;
    int lo;
    int v;
    int noise_span;
    bit in_dip;
    thr = int'(model_threshold);
    len = ($urandom_range(9, 0) == 0) ? $urandom_range(3, 1) : $urandom_range(40, 4);
    hi = $urandom_range(65535, (thr < 65535) ? thr + 1 : 65535);
    lo = hi - thr - 1 - int'($urandom_range(thr / 2 + 50, 0));
    if (lo < 0) lo = 0;
    noise_span = thr / 4;
    in_dip = 1'b0;
    for (int i = 0; i < len; i++) begin
      if (in_dip) in_dip = ($urandom_range(2, 0) != 0);
      else in_dip = ($urandom_range(4, 0) == 0);
      if ($urandom_range(11, 0) == 0) v = int'($urandom_range(65535, 0));
      else v = (in_dip ? lo : hi) + int'($urandom_range(noise_span, 0)) - noise_span / 2;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      send_sample(v[15:0], i == len - 1);
    end
  endtask

  task automatic run_random_phase(input logic [rsdd_pkg::THR_W-1:0] thr,
                                  input logic [rsdd_pkg::COFF_W-1:0] coff,
                                  input logic [rsdd_pkg::IOFF_W-1:0] ioff,
                                  input int unsigned count);
    int unsigned stop_at;
    wait_idle();
    set_config(thr, coff, ioff);
    stop_at = sent_items + count;
    while (sent_items < stop_at) send_random_scan();
  endtask

  task automatic test_directed_scans();
    send_scan('{16'hFFFF});
    send_scan('{16'h0000, 16'hFFFF});
    send_scan('{16'd100, 16'd50, 16'd2000, 16'd2000});
    send_scan('{16'd9000, 16'd5000, 16'd1000, 16'd1000, 16'd9000, 16'd20000, 16'd2000,
                16'd2000});
    send_scan('{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF});
  endtask

  task automatic test_config_settings();
    run_random_phase(16'd0, 16'd0, 8'd0, 230);
    run_random_phase(16'hFFFF, 16'hFFFF, 8'hFF, 70);
    run_random_phase(16'($urandom_range(3000, 1)), 16'($urandom_range(65535, 0)),
                     8'($urandom_range(255, 0)), 240);
  endtask

  task automatic test_back_pressure();
    range_list_t pattern;
    wait_idle();
    for (int i = 0; i < 20; i++) begin
      pattern = {pattern, 16'd9000};
      pattern = {pattern, 16'd100};
      pattern = {pattern, 16'd100};
    end
    pattern = {pattern, 16'd9000};
    sender_gaps = 1'b0;
    hold_request = 1'b1;
    send_scan(pattern);
    sender_gaps = 1'b1;
  endtask

  task automatic test_steady_stream();
    run_random_phase(rsdd_pkg::JUMP_THRESHOLD_RST, rsdd_pkg::CENTER_OFFSET_RST,
                     rsdd_pkg::INDEX_OFFSET_RST, 250);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (250) @(posedge clk);
      end else if (receiver_gaps && $urandom_range(6, 0) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(18, 1)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    rsdd_pkg::result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_segments.size() == 0) begin
          report_mismatch("result with none pending", out_seg_start, 0);
        end else begin
          want = pending_segments.pop_front();
          if (out_seg_start !== want.seg_start)
            report_mismatch("seg_start", out_seg_start, want.seg_start);
          if (out_seg_end !== want.seg_end)
            report_mismatch("seg_end", out_seg_end, want.seg_end);
          if (out_closest_index !== want.closest_index)
            report_mismatch("closest_index", out_closest_index, want.closest_index);
          if (out_center_range_mm !== want.center_range_mm)
            report_mismatch("center_range_mm", out_center_range_mm, want.center_range_mm);
          if (out_scan_done !== want.scan_done)
            report_mismatch("scan_done", out_scan_done, want.scan_done);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    clear_scan_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    test_directed_scans();
    test_config_settings();
    test_back_pressure();
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    test_steady_stream();
    in_valid <= 1'b0;
    for (int c = 0; c < 2000 && pending_segments.size() != 0; c++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_segments.size() != 0)
      report_mismatch("segments never delivered", 0, pending_segments.size());
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
